[rtl/n2a_pkg.sv]
// n2a_pkg: shared types, constants and helpers for the number-to-ascii formatter
// no dependencies
package n2a_pkg;

  localparam int NUM_CELLS    = 16;
  localparam int DIG_W        = 4;
  localparam int DEC_BITS     = 32;
  localparam int HEX32_DIGITS = 8;
  localparam int HEX64_DIGITS = 16;
  localparam int CNT_W        = 5;

  typedef enum logic [1:0] {
    OP_DEC   = 2'd0,
    OP_HEX32 = 2'd1,
    OP_HEX64 = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       feed;
  } chain_ctrl_t;

  function automatic logic [7:0] hex_char(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h37 + {4'h0, d};
    end
    return c;
  endfunction

endpackage

[rtl/n2a_cell.sv]
// n2a_cell: one digit position of the chain; hold, load, double-dabble step or shift
// depends on n2a_pkg
module n2a_cell import n2a_pkg::*; (
  input  logic             clk,
  input  cell_mode_t       mode,
  input  logic [DIG_W-1:0] load_nib,
  input  logic             carry_in,
  input  logic [DIG_W-1:0] dig_in,
  output logic             carry_out,
  output logic [DIG_W-1:0] dig_out
);

  logic [DIG_W-1:0] dig_r;
  logic [DIG_W-1:0] dig_nxt;
  logic [DIG_W-1:0] adj;

  always_comb begin
    adj = (dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
    unique case (mode)
      CELL_HOLD:   dig_nxt = dig_r;
      CELL_LOAD:   dig_nxt = load_nib;
      CELL_DABBLE: dig_nxt = {adj[DIG_W-2:0], carry_in};
      CELL_SHIFT:  dig_nxt = dig_in;
      default:     dig_nxt = dig_r;
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign carry_out = adj[DIG_W-1];
  assign dig_out   = dig_r;

endmodule

[rtl/n2a_ctrl.sv]
// n2a_ctrl: sequencer for the digit chain, binary feed and output register
// depends on n2a_pkg
module n2a_ctrl import n2a_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [DEC_BITS-1:0] in_bin,
  input  logic [DIG_W-1:0]    top_digit,
  output chain_ctrl_t         chain_ctrl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char_out,
  output logic                out_last
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DEC_BITS-1:0] bin_r, bin_nxt;
  logic                skip_r, skip_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_free;

  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(DEC_BITS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    bin_nxt         = bin_r;
    skip_nxt        = skip_r;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    out_free        = !out_valid_r || out_ready;
    out_valid_nxt   = out_valid_r && !out_ready;
    in_ready        = 1'b0;
    chain_ctrl.mode = CELL_HOLD;
    chain_ctrl.feed = bin_r[DEC_BITS-1];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_DEC: begin
              chain_ctrl.mode = CELL_LOAD;
              bin_nxt         = in_bin;
              cnt_nxt         = '0;
              skip_nxt        = 1'b1;
              state_nxt       = ST_CONV;
            end
            OP_HEX32: begin
              chain_ctrl.mode = CELL_LOAD;
              cnt_nxt         = CNT_W'(HEX32_DIGITS);
              skip_nxt        = 1'b0;
              state_nxt       = ST_EMIT;
            end
            OP_HEX64: begin
              chain_ctrl.mode = CELL_LOAD;
              cnt_nxt         = CNT_W'(HEX64_DIGITS);
              skip_nxt        = 1'b0;
              state_nxt       = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        chain_ctrl.mode = CELL_DABBLE;
        bin_nxt         = {bin_r[DEC_BITS-2:0], 1'b0};
        if (cnt_r == CONV_LAST) begin
          cnt_nxt   = CNT_W'(NUM_CELLS);
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end
      ST_EMIT: begin
        if (skip_r && top_digit == '0 && cnt_r != CNT_ONE) begin
          // leading zero, drop it
          chain_ctrl.mode = CELL_SHIFT;
          cnt_nxt         = cnt_r - CNT_ONE;
        end else if (out_free) begin
          chain_ctrl.mode = CELL_SHIFT;
          out_valid_nxt   = 1'b1;
          out_char_nxt    = hex_char(top_digit);
          out_last_nxt    = (cnt_r == CNT_ONE);
          skip_nxt        = 1'b0;
          cnt_nxt         = cnt_r - CNT_ONE;
          if (cnt_r == CNT_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

[rtl/number_to_ascii_formatter.sv]
// number_to_ascii_formatter: top level, chain of 16 digit cells plus sequencer
// depends on n2a_pkg, n2a_cell, n2a_ctrl
//
// usage
//   input channel (in_valid/in_ready, in_op, in_value) takes one number and a
//   format: decimal of the low 32 bits, 8 hex digits, or 16 hex digits.
//   output channel (out_valid/out_ready, out_char_out, out_last) gives one
//   ascii character per transaction, most significant first, out_last high
//   on the final character. an unused format code is taken and dropped.
// timing
//   the number is loaded into a row of 4-bit cells. hex modes shift the row
//   out one digit per cycle while the receiver keeps up. decimal runs 32
//   double-dabble steps through the cells (one input bit per cycle), then
//   walks the 16 positions, dropping leading zeros. in_ready is high only
//   while no number is in the chain; the next number is taken while the
//   last character still sits in the output register.
// reset and stall
//   synchronous active-low reset idles the sequencer and clears out_valid
//   but not the cells. a stall holds the output register and the next digit.
module number_to_ascii_formatter import n2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_last
);

  chain_ctrl_t      chain_ctrl;
  logic [DIG_W-1:0] load_nib [NUM_CELLS];
  logic [DIG_W-1:0] dig_chain [NUM_CELLS+1];
  logic             carry_chain [NUM_CELLS];

  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      unique case (in_op)
        OP_HEX64: load_nib[i] = in_value[DIG_W*i +: DIG_W];
        OP_HEX32: begin
          if (i >= NUM_CELLS - HEX32_DIGITS) begin
            load_nib[i] = in_value[DIG_W*(i-(NUM_CELLS-HEX32_DIGITS)) +: DIG_W];
          end else begin
            load_nib[i] = '0;
          end
        end
        default:  load_nib[i] = '0;
      endcase
    end
  end

  assign dig_chain[0]   = '0;
  assign carry_chain[0] = chain_ctrl.feed;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i < NUM_CELLS - 1) begin : g_mid
      n2a_cell u_cell (
        .clk       (clk),
        .mode      (chain_ctrl.mode),
        .load_nib  (load_nib[i]),
        .carry_in  (carry_chain[i]),
        .dig_in    (dig_chain[i]),
        .carry_out (carry_chain[i+1]),
        .dig_out   (dig_chain[i+1])
      );
    end else begin : g_top
      n2a_cell u_cell (
        .clk       (clk),
        .mode      (chain_ctrl.mode),
        .load_nib  (load_nib[i]),
        .carry_in  (carry_chain[i]),
        .dig_in    (dig_chain[i]),
        .carry_out (),
        .dig_out   (dig_chain[i+1])
      );
    end
  end

  n2a_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_bin       (in_value[DEC_BITS-1:0]),
    .top_digit    (dig_chain[NUM_CELLS]),
    .chain_ctrl   (chain_ctrl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

endmodule

[rtl/n2a_checker.sv]
// n2a_checker: port-level checks for number_to_ascii_formatter, bound to the top
// depends on n2a_pkg
module n2a_checker import n2a_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_last
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_last))
    else $error("output changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_out >= 8'h30 && out_char_out <= 8'h39) ||
                  (out_char_out >= 8'h41 && out_char_out <= 8'h46))
    else $error("output is not a digit character");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_DEC || in_op == OP_HEX32 || in_op == OP_HEX64)
    |=> !in_ready)
    else $error("new transaction taken while a number is in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op != OP_DEC && in_op != OP_HEX32 && in_op != OP_HEX64
    |=> in_ready)
    else $error("unused format code blocked the input");

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_char_out (out_char_out),
  .out_last     (out_last)
);

[dv/number_to_ascii_formatter_test.sv]
// number_to_ascii_formatter_test: self-checking bench for the number-to-ascii formatter
// drives directed and random numbers with bursty input and a stalling receiver
// depends on n2a_pkg and number_to_ascii_formatter
module number_to_ascii_formatter_test;
  import n2a_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_DIR = 22;
  localparam int N_RANDOM = 240;
  localparam int NO_IDLE_FIRST = 180;
  localparam int NO_IDLE_LAST = 230;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 30;
  localparam logic [127:0] DIGIT_CHARS = "0123456789ABCDEF";

  typedef logic [127:0] text_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_beat_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        typed;
    text_t       text;
  } dir_row_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_t;

  // typed rows carry their text, the rest go through the predictor
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_DEC,    64'd0,                    1'b1, text_t'("0")},
    '{OP_DEC,    64'd1,                    1'b1, text_t'("1")},
    '{OP_DEC,    64'd9,                    1'b1, text_t'("9")},
    '{OP_DEC,    64'd10,                   1'b1, text_t'("10")},
    '{OP_DEC,    64'd999999999,            1'b1, text_t'("999999999")},
    '{OP_DEC,    64'd1000000000,           1'b1, text_t'("1000000000")},
    '{OP_DEC,    64'h0000_0000_FFFF_FFFF,  1'b1, text_t'("4294967295")},
    '{OP_DEC,    64'hFFFF_FFFF_0000_0000,  1'b1, text_t'("0")},
    '{OP_DEC,    64'h1234_5678_0000_007B,  1'b1, text_t'("123")},
    '{OP_DEC,    64'h0000_0000_8000_0000,  1'b0, text_t'(0)},
    '{OP_HEX32,  64'd0,                    1'b1, text_t'("00000000")},
    '{OP_HEX32,  64'h0000_0000_FFFF_FFFF,  1'b1, text_t'("FFFFFFFF")},
    '{OP_HEX32,  64'hDEAD_BEEF_89AB_CDEF,  1'b1, text_t'("89ABCDEF")},
    '{OP_HEX32,  64'h0000_0000_0123_4567,  1'b1, text_t'("01234567")},
    '{OP_HEX64,  64'd0,                    1'b1, text_t'("0000000000000000")},
    '{OP_HEX64,  64'hFFFF_FFFF_FFFF_FFFF,  1'b1, text_t'("FFFFFFFFFFFFFFFF")},
    '{OP_HEX64,  64'h0123_4567_89AB_CDEF,  1'b1, text_t'("0123456789ABCDEF")},
    '{OP_HEX64,  64'hFEDC_BA98_7654_3210,  1'b0, text_t'(0)},
    '{OP_HEX64,  64'h8000_0000_0000_0001,  1'b0, text_t'(0)},
    '{OP_UNUSED, 64'h0000_0000_0000_0123,  1'b1, text_t'(0)},
    '{OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, text_t'(0)},
    '{OP_DEC,    64'hAAAA_5555_0000_0064,  1'b1, text_t'("100")}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char_out;
  logic        out_last;

  ascii_beat_t pending_chars[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  number_to_ascii_formatter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] digit_char(logic [3:0] d);
    return DIGIT_CHARS[8 * (15 - int'(d)) +: 8];
  endfunction

  // text is right-justified, one byte per character, zero bytes unused
  function automatic text_t format_number(logic [1:0] op, logic [63:0] value);
    text_t       text;
    logic [31:0] rest;
    int          n;
    text = '0;
    rest = value[31:0];
    n = 0;
    case (op)
      OP_DEC: begin
        do begin
          text[8 * n +: 8] = digit_char(4'(rest % 32'd10));
          rest = rest / 32'd10;
          n++;
        end while (rest != 32'd0);
      end
      OP_HEX32: begin
        for (n = 0; n < 8; n++) text[8 * n +: 8] = digit_char(value[4 * n +: 4]);
      end
      OP_HEX64: begin
        for (n = 0; n < 16; n++) text[8 * n +: 8] = digit_char(value[4 * n +: 4]);
      end
      default: begin
        text = '0;
      end
    endcase
    return text;
  endfunction

  task automatic queue_text(text_t text);
    int top;
    int k;
    top = -1;
    for (k = 15; k >= 0; k--) begin
      if (top < 0 && text[8 * k +: 8] != 8'h00) top = k;
    end
    for (k = top; k >= 0; k--) begin
      pending_chars.push_back('{ch: text[8 * k +: 8], last: (k == 0)});
    end
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  task automatic send_number(logic [1:0] op, logic [63:0] value, text_t text);
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    queue_text(text);
  endtask

  // bursts of back-to-back transactions separated by random gaps
  task automatic pace_sender(bit no_idle);
    int gap;
    if (burst_left > 0) burst_left--;
    if (!no_idle && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value(logic [1:0] op);
    logic [31:0] low;
    logic [31:0] power;
    int          pick;
    int          k;
    pick = $urandom_range(0, 99);
    low = $urandom;
    if (op == OP_DEC && pick < 25) begin
      power = 32'd1;
      for (k = $urandom_range(1, 9); k > 0; k--) power = power * 32'd10;
      low = power + 32'($urandom_range(0, 2)) - 32'd1;
    end else if (op == OP_DEC && pick < 35) begin
      low = 32'($urandom_range(0, 20));
    end else if (pick < 65) begin
      low = low >> $urandom_range(0, 31);
    end
    if (op == OP_HEX64 && pick >= 80) begin
      return {$urandom, $urandom} >> $urandom_range(0, 63);
    end
    return {32'($urandom), low};
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("number_to_ascii_formatter_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    ascii_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", out_char_out, out_last));
      end else begin
        want = pending_chars.pop_front();
        if (out_char_out !== want.ch) begin
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h", out_char_out, want.ch));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                    out_last, want.last, want.ch));
        end
      end
    end
  end

  // receiver stalls according to a mode picked at random for each random span
  initial begin
    rx_mode_t    mode;
    logic [15:0] pattern;
    int          span;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      pattern = 16'($urandom) | 16'h0001;
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_FREE: out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
          end
        endcase
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [63:0] value;
    text_t       text;
    int          sent;
    int          pick;
    bit          drained_once;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_DEC;
    in_value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      text = DIR_ROWS[i].typed ? DIR_ROWS[i].text
                               : format_number(DIR_ROWS[i].op, DIR_ROWS[i].value);
      send_number(DIR_ROWS[i].op, DIR_ROWS[i].value, text);
      pace_sender(1'b0);
    end

    sent = 0;
    drained_once = 1'b0;
    while (sent < N_RANDOM) begin
      if (!drained_once && sent == N_RANDOM / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        drained_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) op = OP_UNUSED;
      else if (pick < 40) op = OP_DEC;
      else if (pick < 70) op = OP_HEX32;
      else op = OP_HEX64;
      value = random_value(op);
      send_number(op, value, format_number(op, value));
      if (op != OP_UNUSED) sent++;
      pace_sender(sent >= NO_IDLE_FIRST && sent < NO_IDLE_LAST);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("number_to_ascii_formatter_test: PASS");
    end else begin
      $display("number_to_ascii_formatter_test: FAIL");
    end
    $finish;
  end

endmodule
